// ===== design/fisr_pkg.sv =====
// Shared types, constants and float helpers for the fast inverse square root.
// Depends on nothing.
package fisr_pkg;

    localparam int unsigned MagicReset = 32'h5f3759df;
    localparam logic [1:0] StepsReset = 2'd1;
    localparam logic [31:0] CanonNan = 32'h7FC00000;
    localparam logic [31:0] FloatHalf = 32'h3F000000;
    localparam logic [31:0] FloatThreeHalves = 32'h3FC00000;

    typedef enum logic [0:0] {
        CFG_MAGIC = 1'b0,
        CFG_STEPS = 1'b1
    } t_cfg_index;

    // float op done by one pipeline stage
    typedef enum logic [2:0] {
        OP_HALF = 3'd0,
        OP_HY   = 3'd1,
        OP_TY   = 3'd2,
        OP_SUB  = 3'd3,
        OP_UPD  = 3'd4
    } t_op;

    // x holds the input, then 0.5*x; t is the scratch term of a Newton step
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] t;
        logic [1:0]  steps;
    } t_item;

    // round-to-nearest-even single precision multiply
    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        logic        sa;
        logic        sb;
        logic        sr;
        logic [7:0]  ea;
        logic [7:0]  eb;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [47:0] p;
        logic signed [10:0] e;
        logic [49:0] w;
        logic [5:0]  lz;
        logic [26:0] m;
        logic [24:0] mr;
        logic        st;
        logic [31:0] r;
        logic [5:0]  sh;
        logic        found;
        sa = a[31];
        sb = b[31];
        sr = sa ^ sb;
        ea = a[30:23];
        eb = b[30:23];
        ma = {(ea != 8'd0), a[22:0]};
        mb = {(eb != 8'd0), b[22:0]};
        r = 32'd0;
        if ((ea == 8'hFF && a[22:0] != 23'd0) || (eb == 8'hFF && b[22:0] != 23'd0)) begin
            r = CanonNan;
        end else if (ea == 8'hFF || eb == 8'hFF) begin
            if ((ea == 8'd0 && a[22:0] == 23'd0) || (eb == 8'd0 && b[22:0] == 23'd0)) begin
                r = CanonNan;
            end else begin
                r = {sr, 8'hFF, 23'd0};
            end
        end else if (ma == 24'd0 || mb == 24'd0) begin
            r = {sr, 31'd0};
        end else begin
            p = ma * mb;
            // product value = p * 2^(e - 46), exponent biased
            e = 11'(signed'({3'd0, ea})) + 11'(signed'({3'd0, eb})) - 11'sd127
                + ((ea == 8'd0) ? 11'sd1 : 11'sd0) + ((eb == 8'd0) ? 11'sd1 : 11'sd0);
            lz = 6'd0;
            found = 1'b0;
            for (int i = 47; i >= 0; i--) begin
                if (!found && p[i]) begin
                    found = 1'b1;
                    lz = 6'(47 - i);
                end
            end
            // normalize so leading one at bit 47; exponent of that = e + 1 - lz
            p = p << lz;
            e = e + 11'sd1 - 11'(signed'({5'd0, lz}));
            w = {p, 2'b00};
            if (e <= 11'sd0) begin
                sh = (e < -11'sd30) ? 6'd32 : 6'(11'sd1 - e);
                w = w >> sh;
                st = ({p, 2'b00} & ~({50{1'b1}} << sh)) != 50'd0;
                e = 11'sd0;
            end else begin
                st = 1'b0;
            end
            // w[49:26] = 24 bit mantissa, w[25] guard, rest sticky
            m = {w[49:26], w[25], 1'b0, (w[24:0] != 25'd0) | st};
            mr = {1'b0, m[26:3]};
            if (m[2] && (m[0] || m[3])) mr = mr + 25'd1;
            if (mr[24]) begin
                mr = mr >> 1;
                e = e + 11'sd1;
            end else if (e == 11'sd0 && mr[23]) begin
                e = 11'sd1;
            end
            if (e >= 11'sd255) r = {sr, 8'hFF, 23'd0};
            else r = {sr, e[7:0], mr[22:0]};
        end
        return r;
    endfunction

    // 1.5 - t, round-to-nearest-even
    function automatic logic [31:0] fsub15(input logic [31:0] t);
        logic        st;
        logic [7:0]  et;
        logic [23:0] mt;
        logic [7:0]  d;
        logic [51:0] ab;
        logic [51:0] bb;
        logic [52:0] s;
        logic        neg;
        logic [5:0]  lz;
        logic        found;
        logic signed [10:0] e;
        logic [26:0] m;
        logic [24:0] mr;
        logic [31:0] r;
        st = t[31];
        et = t[30:23];
        mt = {(et != 8'd0), t[22:0]};
        r = 32'd0;
        if (et == 8'hFF) begin
            r = (t[22:0] != 23'd0) ? CanonNan : {~st, 8'hFF, 23'd0};
        end else begin
            // 1.5 has exponent 127; align both on a 52-bit frame
            if (et > 8'd127) begin
                e = 11'(signed'({3'd0, et}));
                d = et - 8'd127;
                ab = {mt, 28'd0};
                bb = (d > 8'd51) ? 52'd1 : ({24'hC00000, 28'd0} >> d);
                if (d <= 8'd51 && (({24'hC00000, 28'd0} & ~({52{1'b1}} << d)) != 52'd0))
                    bb[0] = 1'b1;
                s = st ? ({1'b0, bb} + {1'b0, ab}) : ({1'b0, ab} - {1'b0, bb});
                neg = ~st;
            end else begin
                e = 11'sd127;
                d = 8'd127 - ((et == 8'd0) ? 8'd1 : et);
                ab = {24'hC00000, 28'd0};
                bb = (d > 8'd51) ? ((mt != 0) ? 52'd1 : 52'd0) : ({mt, 28'd0} >> d);
                if (d <= 8'd51 && (({mt, 28'd0} & ~({52{1'b1}} << d)) != 52'd0))
                    bb[0] = 1'b1;
                if (st) begin
                    s = {1'b0, ab} + {1'b0, bb};
                    neg = 1'b0;
                end else if (ab >= bb) begin
                    s = {1'b0, ab} - {1'b0, bb};
                    neg = 1'b0;
                end else begin
                    s = {1'b0, bb} - {1'b0, ab};
                    neg = 1'b1;
                end
            end
            if (s == 53'd0) begin
                r = 32'd0;
            end else begin
                lz = 6'd0;
                found = 1'b0;
                for (int i = 52; i >= 0; i--) begin
                    if (!found && s[i]) begin
                        found = 1'b1;
                        lz = 6'(52 - i);
                    end
                end
                s = s << lz;
                e = e + 11'sd1 - 11'(signed'({5'd0, lz}));
                m = {s[52:29], s[28], 1'b0, s[27:0] != 28'd0};
                mr = {1'b0, m[26:3]};
                if (m[2] && (m[0] || m[3])) mr = mr + 25'd1;
                if (mr[24]) begin
                    mr = mr >> 1;
                    e = e + 11'sd1;
                end
                if (e >= 11'sd255) r = {neg, 8'hFF, 23'd0};
                else if (e <= 11'sd0) r = {neg, 31'd0};
                else r = {neg, e[7:0], mr[22:0]};
            end
        end
        return r;
    endfunction

endpackage

// ===== design/fisr_if.sv =====
// Valid/ready channel carrying one 32-bit float word.
// Depends on nothing.
interface fisr_if;
    logic        valid;
    logic        ready;
    logic [31:0] bits;
    modport source (output valid, output bits, input ready);
    modport sink (input valid, input bits, output ready);
endinterface

// ===== design/fisr_stage.sv =====
// One pipeline register stage with stall; applies one fixed float op.
// Depends on fisr_pkg.
module fisr_stage
    import fisr_pkg::*;
#(
    parameter t_op        OP = OP_HALF,
    parameter logic [1:0] STEP = 2'd0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_en,
    output logic  o_valid,
    output t_item o_item
);
    t_item n_item;
    logic  r_valid;
    t_item r_item;

    always_comb begin
        n_item = i_item;
        case (OP)
            OP_HALF: n_item.x = fmul(i_item.x, FloatHalf);
            OP_HY:   n_item.t = fmul(i_item.x, i_item.y);
            OP_TY:   n_item.t = fmul(i_item.t, i_item.y);
            OP_SUB:  n_item.t = fsub15(i_item.t);
            OP_UPD: begin
                // step not applied: y passes through unchanged
                if (i_item.steps >= STEP) n_item.y = fmul(i_item.y, i_item.t);
            end
            default: n_item = i_item;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item = r_item;
endmodule

// ===== design/fast_inverse_square_root.sv =====
// Fast inverse square root top level: guess, up to two Newton steps, output.
// Depends on fisr_pkg, fisr_if, fisr_stage.
//
// Usage: words enter on i_in.bits and leave on o_out.bits,
// valid/ready, one word per cycle when the receiver keeps ready high.
// There are ten register stages: the guess register, the half-x
// multiply, then per Newton step two multiplies, the subtract from 1.5 and
// the y update (both steps are always in the pipe; an unused step leaves y
// as it is). Throughput is one word per cycle while the receiver keeps
// ready high: every stage takes a new word each cycle unless the pipe holds.
// Writes go through i_cfg_we / i_cfg_index / i_cfg_data; index 0 is the
// magic constant, index 1 the step count (3 acts as 2). Write only while idle.
// Reset (synchronous, low) empties the pipe and restores the magic constant
// and one step. When the receiver stalls, the whole pipe holds; the input
// side is not ready while the last stage holds an untaken word.
module fast_inverse_square_root
    import fisr_pkg::*;
#(
    parameter logic [31:0] MAGIC_RESET = MagicReset
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fisr_if.sink        i_in,
    fisr_if.source      o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int NumStages = 9;

    logic [31:0] r_magic;
    logic [1:0]  r_steps;
    logic        en;
    logic        r_valid0;
    t_item       r_item0;
    t_item       last;

    logic        v [NumStages+1];
    t_item       it [NumStages+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= MAGIC_RESET;
            r_steps <= StepsReset;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_MAGIC: r_magic <= i_cfg_data;
                CFG_STEPS: r_steps <= i_cfg_data[1:0];
                default: r_steps <= r_steps;
            endcase
        end
    end

    assign en = !v[NumStages] || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else if (en) begin
            r_valid0 <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_item0.x <= i_in.bits;
            r_item0.y <= r_magic - {1'b0, i_in.bits[31:1]};
            r_item0.t <= 32'd0;
            r_item0.steps <= (r_steps == 2'd3) ? 2'd2 : r_steps;
        end
    end

    assign v[0] = r_valid0;
    assign it[0] = r_item0;

    // stage 0 halves x; then four stages per Newton step
    for (genvar g = 0; g < NumStages; g++) begin : g_st
        localparam t_op Op = (g == 0) ? OP_HALF : t_op'((g - 1) % 4 + 1);
        localparam logic [1:0] Stp = (g == 0) ? 2'd0 : 2'((g - 1) / 4 + 1);
        fisr_stage #(
            .OP   (Op),
            .STEP (Stp)
        ) u_stage (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v[g]), .i_item(it[g]),
            .i_en(en), .o_valid(v[g+1]), .o_item(it[g+1])
        );
    end

    assign last = it[NumStages];

    // a raw guess goes out as is; a refined NaN goes out as the quiet NaN
    assign o_out.valid = v[NumStages];
    assign o_out.bits = (last.steps != 2'd0 && last.y[30:23] == 8'hFF &&
                         last.y[22:0] != 23'd0) ? CanonNan : last.y;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid)
        else $error("output word dropped under stall");
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> $stable(o_out.bits))
        else $error("output word changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled with empty output");
`endif
endmodule

// ===== test/tb_fast_inverse_square_root.sv =====
// Testbench for the fast inverse square root block: bit-exact float predictor,
// bursty source, stalling sink, config phases over magic constant and step count.
// Depends on fisr_pkg, fisr_if and the fast_inverse_square_root RTL.
module tb_fast_inverse_square_root;
    import fisr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 24;

    typedef struct {
        logic [31:0] value;
        bit          known;
        logic [31:0] result;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [31:0] i_cfg_data = '0;

    fisr_if in_if ();
    fisr_if out_if ();

    fast_inverse_square_root uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if.sink),
        .o_out       (out_if.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    logic [31:0] model_magic = MagicReset;
    logic [1:0]  model_steps = StepsReset;
    logic [31:0] rsqrt_due[$];
    int          mismatches = 0;
    bit          failed = 1'b0;

    // value = mag * 2^ex, rounded to nearest even single precision
    function automatic logic [31:0] round_float(bit s, logic [191:0] mag, int ex);
        int p;
        int sh;
        int l;
        int biased;
        logic [191:0] q;
        logic [191:0] rem;
        logic [191:0] halfv;
        if (mag == '0) return {s, 31'd0};
        p = 0;
        for (int i = 0; i < 192; i++) if (mag[i]) p = i;
        if (p + ex + 127 >= 1) sh = p - 23;
        else sh = -149 - ex;
        if (sh <= 0) begin
            q = mag << (-sh);
        end else if (sh > 190) begin
            q = '0;
        end else begin
            q = mag >> sh;
            rem = mag & ((192'd1 << sh) - 192'd1);
            halfv = 192'd1 << (sh - 1);
            if (rem > halfv || (rem == halfv && q[0])) q = q + 192'd1;
        end
        l = ex + sh;
        if (q[24]) begin
            q = q >> 1;
            l = l + 1;
        end
        if (!q[23]) return {s, 8'd0, q[22:0]};
        biased = l + 150;
        if (biased >= 255) return {s, 8'hFF, 23'd0};
        return {s, 8'(biased), q[22:0]};
    endfunction

    function automatic bit is_nan(logic [31:0] a);
        return a[30:23] == 8'hFF && a[22:0] != 23'd0;
    endfunction

    function automatic logic [31:0] float_mul(logic [31:0] a, logic [31:0] b);
        bit s;
        logic [23:0] ma;
        logic [23:0] mb;
        int xa;
        int xb;
        s = a[31] ^ b[31];
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        if (is_nan(a) || is_nan(b)) return CanonNan;
        if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) begin
            if (a[30:0] == '0 || b[30:0] == '0) return CanonNan;
            return {s, 8'hFF, 23'd0};
        end
        if (ma == '0 || mb == '0) return {s, 31'd0};
        xa = (a[30:23] == 8'd0) ? -149 : int'(a[30:23]) - 150;
        xb = (b[30:23] == 8'd0) ? -149 : int'(b[30:23]) - 150;
        return round_float(s, 192'(ma) * 192'(mb), xa + xb);
    endfunction

    // 1.5 - t
    function automatic logic [31:0] three_halves_minus(logic [31:0] t);
        logic [23:0]  mt;
        logic [191:0] a;
        logic [191:0] ta;
        int te;
        int base;
        if (is_nan(t)) return CanonNan;
        if (t[30:23] == 8'hFF) return {~t[31], 8'hFF, 23'd0};
        mt = {t[30:23] != 8'd0, t[22:0]};
        if (mt == '0) return FloatThreeHalves;
        te = (t[30:23] == 8'd0) ? -149 : int'(t[30:23]) - 150;
        if (te >= -1) begin
            base = -1;
            a = 192'd3;
            ta = 192'(mt) << (te + 1);
        end else if (te >= -101) begin
            base = te;
            a = 192'd3 << (-1 - te);
            ta = 192'(mt);
        end else begin
            // far below the rounding point: only its sign and presence matter
            base = -101;
            a = 192'd3 << 100;
            ta = 192'd1;
        end
        if (t[31]) return round_float(1'b0, a + ta, base);
        if (a >= ta) return round_float(1'b0, a - ta, base);
        return round_float(1'b1, ta - a, base);
    endfunction

    function automatic logic [31:0] predict_rsqrt(logic [31:0] xb);
        logic [31:0] y;
        logic [31:0] half_x;
        logic [31:0] t;
        int n;
        y = model_magic - (xb >> 1);
        n = (model_steps > 2'd2) ? 2 : int'(model_steps);
        if (n == 0) return y;
        half_x = float_mul(xb, FloatHalf);
        for (int k = 0; k < n; k++) begin
            t = float_mul(float_mul(half_x, y), y);
            y = float_mul(y, three_halves_minus(t));
        end
        return is_nan(y) ? CanonNan : y;
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom();
            3:       return {1'b0, 8'd0, 23'($urandom())};
            4:       return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(0, 3))};
            5:       return {1'b0, 8'($urandom_range(0, 255)), 23'($urandom_range(0, 3))};
            default: return {1'b0, 8'($urandom_range(1, 254)), 23'($urandom())};
        endcase
    endfunction

    // sink: ready pattern switches among four modes, picked at random
    int sink_cycle = 0;
    int sink_mode = 0;
    initial out_if.ready = 1'b0;
    always @(negedge i_clk) begin
        sink_cycle <= sink_cycle + 1;
        if (sink_cycle % 64 == 0) sink_mode <= $urandom_range(0, 3);
        case (sink_mode)
            0:       out_if.ready <= 1'b1;
            1:       out_if.ready <= $urandom_range(0, 1);
            2:       out_if.ready <= ($urandom_range(0, 4) == 0);
            default: out_if.ready <= (sink_cycle % 7) < 4;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (rsqrt_due.size() == 0) begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %08h", out_if.bits);
            end else begin
                logic [31:0] want;
                want = rsqrt_due.pop_front();
                if (out_if.bits !== want) begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result_bits mismatch: expected %08h got %08h",
                                 want, out_if.bits);
                end
            end
        end
    end

    int burst_left = 0;

    task automatic send_word(logic [31:0] v, bit known, logic [31:0] typed);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                in_if.valid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_if.valid = 1'b1;
        in_if.bits = v;
        do @(posedge i_clk); while (!in_if.ready);
        rsqrt_due = {rsqrt_due, (known ? typed : predict_rsqrt(v))};
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        in_if.valid = 1'b0;
        while (rsqrt_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [31:0] data);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_MAGIC) model_magic = data;
        else model_steps = data[1:0];
    endtask

    t_row directed[16] = '{
        '{32'h0000_0000, 1'b0, 32'h0},
        '{32'h8000_0000, 1'b0, 32'h0},
        '{32'h3F80_0000, 1'b0, 32'h0},
        '{32'h4080_0000, 1'b0, 32'h0},
        '{32'h0000_0001, 1'b0, 32'h0},
        '{32'h007F_FFFF, 1'b0, 32'h0},
        '{32'h0080_0000, 1'b0, 32'h0},
        '{32'h7F7F_FFFF, 1'b0, 32'h0},
        '{32'h7F80_0000, 1'b1, 32'hFF80_0000},
        '{32'hFF80_0000, 1'b0, 32'h0},
        '{32'h7FC0_0000, 1'b1, CanonNan},
        '{32'h7F80_0001, 1'b1, CanonNan},
        '{32'hFFFF_FFFF, 1'b1, CanonNan},
        '{32'hBF80_0000, 1'b0, 32'h0},
        '{32'hAAAA_AAAA, 1'b0, 32'h0},
        '{32'h5555_5555, 1'b0, 32'h0}
    };

    initial begin
        logic [31:0] magics[7];
        logic [1:0]  steps[7];
        in_if.valid = 1'b0;
        in_if.bits = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (directed[i]) send_word(directed[i].value, directed[i].known, directed[i].result);

        magics = '{MagicReset, MagicReset, MagicReset, 32'h0, 32'hFFFF_FFFF,
                   32'h5f37_5a86, $urandom()};
        steps = '{2'd0, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'($urandom_range(0, 3))};
        for (int ph = 0; ph < 7; ph++) begin
            wait_idle();
            write_reg(CFG_MAGIC, magics[ph]);
            write_reg(CFG_STEPS, {30'd0, steps[ph]});
            // zero magic with a zero input keeps the guess and every step at zero
            if (ph == 3) send_word(32'h0, 1'b0, 32'h0);
            for (int n = 0; n < 105; n++) send_word(random_value(), 1'b0, 32'h0);
        end
        wait_idle();
        if (!failed) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
